// ----- hw/rtl/sma_pkg.sv -----
// Shared constants and types for the simple moving average block.
// No dependencies; used by sma_divider and simple_moving_average.
package sma_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int PRICE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
    localparam int LEN_BITS   = SLOT_BITS + 1;
    localparam int SUM_BITS   = 40;
    localparam int AVG_BITS   = 32;
    localparam int CNT_BITS   = $clog2(SUM_BITS);

    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(20);
    localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(MAX_WINDOW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_DONE
    } sma_state_t;

    // Clamp a written window length to 1..MAX_WINDOW.
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
        logic [LEN_BITS-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_BITS'(1);
        end else if (len > LEN_MAX) begin
            res = LEN_MAX;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/sma_divider.sv -----
// Restoring divider, one quotient bit per cycle: SUM_BITS dividend by LEN_BITS divisor.
// Depends on sma_pkg.
module sma_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sma_pkg::SUM_BITS-1:0]  dividend,
    input  logic [sma_pkg::LEN_BITS-1:0]  divisor,
    output logic                          done,
    output logic [sma_pkg::SUM_BITS-1:0]  quotient
);

    logic [sma_pkg::SUM_BITS-1:0] quo_reg, quo_next;
    logic [sma_pkg::LEN_BITS-1:0] rem_reg, rem_next;
    logic [sma_pkg::LEN_BITS-1:0] dvs_reg;
    logic [sma_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [sma_pkg::LEN_BITS:0]   trial;
    logic [sma_pkg::LEN_BITS:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[sma_pkg::SUM_BITS-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[sma_pkg::LEN_BITS-1:0];
                quo_next = {quo_reg[sma_pkg::SUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[sma_pkg::LEN_BITS-1:0];
                quo_next = {quo_reg[sma_pkg::SUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sma_pkg::CNT_BITS'(sma_pkg::SUM_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a run");

endmodule

// ----- hw/rtl/simple_moving_average.sv -----
// Simple moving average over a ring of the last window_length Q16.16 prices.
// Depends on sma_pkg and sma_divider.
//
//   channel   dir   fields
//   s_        in    tdata: price[31:0]   tuser: series_start
//   m_        out   tdata: average[31:0]
//   cfg_      in    cfg_wr_data: window_length[8:0], write-only
//
// An item that gives no result passes through the read state only; one that gives
// a result also runs the 40-step divider (one quotient bit per cycle) before the done state.
// Ring memory read at accept, read-modify-write on the following cycle.
// The result waits in the output register; the next item is accepted meanwhile.
// A second result stalls the input until the output register frees.
// aresetn is synchronous; the ring needs no clearing, only sum, slot and fill reset.
module simple_moving_average (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sma_pkg::PRICE_BITS-1:0]  s_tdata,    // price
    input  logic                            s_tuser,    // series_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sma_pkg::AVG_BITS-1:0]    m_tdata,    // average
    input  logic                            cfg_wr_en,
    input  logic [sma_pkg::LEN_BITS-1:0]    cfg_wr_data
);

    sma_pkg::sma_state_t state_reg, state_next;

    logic [sma_pkg::PRICE_BITS-1:0] ring_mem [0:sma_pkg::MAX_WINDOW-1];
    logic [sma_pkg::PRICE_BITS-1:0] rd_data_reg;
    logic [sma_pkg::SLOT_BITS-1:0]  rd_addr;
    logic                           ram_we;

    logic [sma_pkg::LEN_BITS-1:0]   len_reg;
    logic [sma_pkg::SUM_BITS-1:0]   sum_reg, sum_next;
    logic [sma_pkg::SLOT_BITS-1:0]  wslot_reg, wslot_next;
    logic [sma_pkg::LEN_BITS-1:0]   fill_reg, fill_next;
    logic [sma_pkg::SLOT_BITS-1:0]  cur_slot_reg;
    logic [sma_pkg::PRICE_BITS-1:0] price_reg;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [sma_pkg::AVG_BITS-1:0]   m_tdata_reg;

    logic                           accept;
    logic [sma_pkg::LEN_BITS-1:0]   slot_pick;
    logic [sma_pkg::LEN_BITS-1:0]   slot_inc;
    logic                           full_before;
    logic                           div_start;
    logic                           div_done;
    logic [sma_pkg::SUM_BITS-1:0]   div_quo;
    logic                           out_free;
    logic                           load_out;

    assign s_tready = (state_reg == sma_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        slot_pick = s_tuser ? '0 : {1'b0, wslot_reg};
        if (slot_pick >= len_reg) begin
            slot_pick = '0;
        end
        rd_addr = slot_pick[sma_pkg::SLOT_BITS-1:0];
    end

    always_comb begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        wslot_next  = wslot_reg;
        fill_next   = fill_reg;
        ram_we      = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        full_before = (fill_reg >= len_reg);
        slot_inc    = {1'b0, cur_slot_reg} + 1'b1;
        if (slot_inc >= len_reg) begin
            slot_inc = '0;
        end
        case (state_reg)
            sma_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        sum_next   = '0;
                        wslot_next = '0;
                        fill_next  = '0;
                    end
                    state_next = sma_pkg::ST_READ;
                end
            end
            sma_pkg::ST_READ: begin
                ram_we = 1'b1;
                if (full_before) begin
                    sum_next = sum_reg - sma_pkg::SUM_BITS'(rd_data_reg)
                             + sma_pkg::SUM_BITS'(price_reg);
                end else begin
                    sum_next  = sum_reg + sma_pkg::SUM_BITS'(price_reg);
                    fill_next = fill_reg + 1'b1;
                end
                wslot_next = slot_inc[sma_pkg::SLOT_BITS-1:0];
                if (fill_next >= len_reg) begin
                    div_start  = 1'b1;
                    state_next = sma_pkg::ST_DIV;
                end else begin
                    state_next = sma_pkg::ST_IDLE;
                end
            end
            sma_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = sma_pkg::ST_DONE;
                end
            end
            sma_pkg::ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = sma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sma_pkg::ST_IDLE;
            end
        endcase
        if (cfg_wr_en) begin
            sum_next   = '0;
            wslot_next = '0;
            fill_next  = '0;
        end
        m_tvalid_next = load_out || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sma_pkg::ST_IDLE;
            len_reg      <= sma_pkg::LEN_RESET;
            sum_reg      <= '0;
            wslot_reg    <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            wslot_reg    <= wslot_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                len_reg <= sma_pkg::eff_len(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            price_reg    <= s_tdata;
            cur_slot_reg <= rd_addr;
        end
        if (load_out) begin
            m_tdata_reg <= div_quo[sma_pkg::AVG_BITS-1:0];
        end
    end

    // ring memory, registered read
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ring_mem[cur_slot_reg] <= price_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    sma_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_fill_le_len: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= len_reg)
        else $error("fill count above window length");

    a_slot_lt_len: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wslot_reg} < len_reg)
        else $error("write slot outside window");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == sma_pkg::ST_DIV)
        else $error("divider finished outside divide state");

    a_read_then_write: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ram_we)
        else $error("accepted transfer not written to ring");

endmodule

// ----- tb/simple_moving_average_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for simple_moving_average: stream driver and monitor
// around a cycle-free window predictor. Depends on sma_pkg and the RTL only.
module simple_moving_average_tb;

    localparam int  DRAIN_CYCLES = 60;
    localparam int  LONG_HOLD    = 400;
    localparam int  CYCLE_LIMIT  = 1_500_000;

    typedef logic [sma_pkg::LEN_BITS-1:0]   len_word_t;
    typedef logic [sma_pkg::PRICE_BITS-1:0] price_t;

    typedef struct packed {
        price_t price;
        logic   series_start;
    } price_item_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    price_t     s_tdata     = '0;   // price
    logic       s_tuser     = 1'b0; // series_start
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [sma_pkg::AVG_BITS-1:0] m_tdata;  // average
    logic       cfg_wr_en   = 1'b0;
    len_word_t  cfg_wr_data = '0;

    simple_moving_average dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // window predictor state
    price_t       win_ring [sma_pkg::MAX_WINDOW];
    logic [39:0]  win_sum  = '0;
    int           win_slot = 0;
    int           win_fill = 0;
    len_word_t    win_len  = len_word_t'(20);

    price_item_t  pending_prices [$];
    logic [sma_pkg::AVG_BITS-1:0] expected_averages [$];

    int  error_count     = 0;
    int  prices_sent     = 0;
    int  averages_seen   = 0;
    int  settings_tried  = 1;
    int  gap_max         = 0;
    bit  hold_phase      = 1'b0;
    int  cycle_count     = 0;

    function automatic int window_span();
        if (win_len == '0)
            return 1;
        if (win_len > sma_pkg::MAX_WINDOW)
            return sma_pkg::MAX_WINDOW;
        return int'(win_len);
    endfunction

    // Advance the window by one price; returns 1 when an average is due.
    function automatic bit advance_window(input price_t price, input logic start,
                                          output logic [sma_pkg::AVG_BITS-1:0] avg);
        int          span;
        logic [39:0] quot;
        span = window_span();
        if (start) begin
            win_sum  = '0;
            win_slot = 0;
            win_fill = 0;
        end
        if (win_slot >= span)
            win_slot = 0;
        if (win_fill >= span)
            win_sum -= 40'(win_ring[win_slot]);
        else
            win_fill++;
        win_sum += 40'(price);
        win_ring[win_slot] = price;
        win_slot = (win_slot + 1 >= span) ? 0 : win_slot + 1;
        quot = win_sum / 40'(span);
        avg  = quot[sma_pkg::AVG_BITS-1:0];
        return win_fill >= span;
    endfunction

    function automatic price_t random_price();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return price_t'($urandom_range(0, 255));
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 65535);
            4:       return {16'($urandom_range(50, 200)), 16'($urandom)};
            default: return price_t'($urandom);
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // ---------------- driver ----------------
    price_item_t cur_item;
    bit          loaded     = 1'b0;
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(posedge aclk) begin
        logic [sma_pkg::AVG_BITS-1:0] avg;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            loaded = 1'b0;
        end else begin
            if (loaded && s_tready) begin
                loaded = 1'b0;
                prices_sent++;
                if (advance_window(cur_item.price, cur_item.series_start, avg))
                    expected_averages = {expected_averages, avg};
            end
            if (!loaded) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_prices.size() != 0) begin
                    cur_item = pending_prices.pop_front();
                    loaded   = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_item.price;
                    s_tuser  <= cur_item.series_start;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    int  ready_mode   = 0;
    int  mode_left    = 0;

    always @(posedge aclk) begin
        logic [sma_pkg::AVG_BITS-1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                averages_seen++;
                if (expected_averages.size() == 0) begin
                    note_failure($sformatf("unexpected average 0x%08h", m_tdata));
                end else begin
                    want = expected_averages.pop_front();
                    if (m_tdata !== want)
                        note_failure($sformatf("average expected 0x%08h got 0x%08h",
                                               want, m_tdata));
                end
            end
            if (hold_phase && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 128);
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d averages outstanding",
                     cycle_count, expected_averages.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic wait_drained();
        while (pending_prices.size() != 0 || loaded || expected_averages.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window_length(input int unsigned length);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len_word_t'(length);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        win_len  = len_word_t'(length);
        win_sum  = '0;
        win_slot = 0;
        win_fill = 0;
        settings_tried++;
    endtask

    task automatic push_price(input price_t price, input logic start);
        price_item_t it;
        it.price        = price;
        it.series_start = start;
        pending_prices = {pending_prices, it};
    endtask

    int unsigned phase_lengths [] = '{1, 2, 3, 5, 20, 0, 7, 256, 511, 257, 64, 13, 4, 9, 2};

    initial begin
        int span;
        int count;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default length after reset: full-scale window, then one zero
        for (int i = 0; i < 20; i++)
            push_price('1, 1'b0);
        push_price('0, 1'b0);
        wait_drained();

        // zero length acts as one; series start on every price
        set_window_length(0);
        push_price('0, 1'b1);
        push_price('1, 1'b1);
        wait_drained();

        foreach (phase_lengths[p]) begin
            set_window_length(phase_lengths[p]);
            span  = window_span();
            count = (span >= 64) ? span + 40 : 110;
            // first single-length phase: long output stall with the sender running flat out
            hold_phase = (p == 0);
            gap_max    = (p == 0) ? 0 : $urandom_range(0, 40);
            for (int i = 0; i < count; i++)
                push_price(random_price(), $urandom_range(0, 3 * span + 8) == 0);
            wait_drained();
        end

        while (expected_averages.size() != 0) begin
            void'(expected_averages.pop_front());
            note_failure("expected average never arrived");
        end

        $display("Drove %0d prices over %0d window settings (0, 1..256, 257, 511),",
                 prices_sent, settings_tried);
        $display("checked %0d averages, %0d errors.", averages_seen, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sma_pkg.sv
hw/rtl/sma_divider.sv
hw/rtl/simple_moving_average.sv
tb/simple_moving_average_tb.sv
